/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the trend classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked in the same cycle outside reset.
`define MTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/mtc_pkg.sv */
// ----------------------------------------------------------------------------
// mtc_pkg
// Constants, types and helper functions of the multichannel trend classifier.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int WINDOW_LEN = 10;
  localparam int NUM_CH     = 5;
  localparam int SAMPLE_W   = 32;
  localparam int LIMIT_W    = 31;
  localparam int CONF_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int IDX_W = $clog2(WINDOW_LEN);

  // Least-squares constants for x = 1..N
  localparam int SUM_X     = WINDOW_LEN * (WINDOW_LEN + 1) / 2;
  localparam int SLOPE_DEN = WINDOW_LEN * WINDOW_LEN * (WINDOW_LEN * WINDOW_LEN - 1) / 12;
  localparam int WT_DEN    = 10;
  localparam int COEF_W    = $clog2(WINDOW_LEN * (WINDOW_LEN - 1) / 2 + 1) + 1;
  localparam int PROD_W    = COEF_W + SAMPLE_W;

  // Digit-serial divider: eight quotient bits per cycle
  localparam int NUM_W   = 48;
  localparam int CHUNK_W = 8;
  localparam int DIV_CYC = NUM_W / CHUNK_W;
  localparam int REM_W   = ($clog2(SLOPE_DEN + 1) > 4) ? $clog2(SLOPE_DEN + 1) : 4;

  // Variance arithmetic widths
  localparam int SY_W      = SAMPLE_W + $clog2(WINDOW_LEN) + 1;
  localparam int HALF_W    = SY_W / 2;
  localparam int VAR_W     = 4 * HALF_W;
  localparam int SQ_W      = 2 * SAMPLE_W;
  localparam int VAR_SCALE = WINDOW_LEN * (WINDOW_LEN - 1) * 65536;

  // Lane sequence: walk, drain, divider setup, divider digits, result
  localparam int LANE_STEPS = WINDOW_LEN + 2 + DIV_CYC;
  localparam int STEP_W     = $clog2(LANE_STEPS + 1);

  localparam int WEIGHT [NUM_CH] = '{4, 3, 1, 1, 1};

  localparam logic [CONF_W-1:0] CONF_ANOM   = 7'd95;
  localparam logic [CONF_W-1:0] CONF_OSC    = 7'd80;
  localparam logic [CONF_W-1:0] CONF_SLOPE  = 7'd85;
  localparam logic [CONF_W-1:0] CONF_STABLE = 7'd90;
  localparam logic [CONF_W-1:0] CONF_KEEP   = 7'd60;

  localparam logic signed [NUM_W-1:0] SAT_MAX = NUM_W'(2147483647);
  localparam logic signed [NUM_W-1:0] SAT_MIN = -SAT_MAX - 1;

  typedef enum logic [2:0] {
    TR_STABLE = 3'd0,
    TR_INC    = 3'd1,
    TR_DEC    = 3'd2,
    TR_OSC    = 3'd3,
    TR_ANOM   = 3'd4
  } trend_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LANE,
    S_MERGE,
    S_DONE
  } seq_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STABLE = 3'd0,
    REG_RISE   = 3'd1,
    REG_FALL   = 3'd2,
    REG_OSC    = 3'd3,
    REG_ANOM   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic              run;
    logic [STEP_W-1:0] step;
  } lane_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } mrg_ctrl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] slope;
    logic                       osc;
    logic                       anom;
  } lane_res_t;

  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [CHUNK_W-1:0] quo;
  } div_res_t;

  // Slope weight of window tap k: N*(k+1) - sum(x)
  function automatic logic signed [COEF_W-1:0] tap_coef(input logic [IDX_W-1:0] k);
    int c;
    c = WINDOW_LEN * (int'(k) + 1) - SUM_X;
    return COEF_W'(c);
  endfunction

  // One chunk of restoring long division, MSB first
  function automatic div_res_t div_chunk(input logic [REM_W-1:0]   rem,
                                         input logic [CHUNK_W-1:0] bits,
                                         input logic [REM_W-1:0]   dvsr);
    logic [REM_W:0]   r;
    logic [REM_W-1:0] cur;
    div_res_t         res;
    cur = rem;
    res = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      r = {cur, bits[i]};
      if (r >= {1'b0, dvsr}) begin
        r = r - {1'b0, dvsr};
        res.quo[i] = 1'b1;
      end
      cur = r[REM_W-1:0];
    end
    res.rem = cur;
    return res;
  endfunction

  // Clamp to the signed sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [NUM_W-1:0] v);
    logic signed [NUM_W-1:0] c;
    c = v;
    if (v > SAT_MAX) c = SAT_MAX;
    if (v < SAT_MIN) c = SAT_MIN;
    return SAMPLE_W'(c);
  endfunction

endpackage

/* rtl/mtc_if.sv */
// ----------------------------------------------------------------------------
// mtc interfaces
// Valid/ready channels for sample items, result items and register writes.
// ----------------------------------------------------------------------------
interface mtc_in_if;
  import mtc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] velocity_sample;
  logic signed [SAMPLE_W-1:0] altitude_sample;
  logic signed [SAMPLE_W-1:0] temperature_sample;
  logic signed [SAMPLE_W-1:0] pressure_sample;
  logic signed [SAMPLE_W-1:0] mach_sample;

  modport source (output valid, velocity_sample, altitude_sample, temperature_sample,
                  pressure_sample, mach_sample, input ready);
  modport sink (input valid, velocity_sample, altitude_sample, temperature_sample,
                pressure_sample, mach_sample, output ready);
endinterface

interface mtc_out_if;
  import mtc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 trend_state;
  logic [CONF_W-1:0]          confidence_pct;
  logic                       window_full;
  logic signed [SAMPLE_W-1:0] velocity_slope;
  logic signed [SAMPLE_W-1:0] altitude_slope;
  logic signed [SAMPLE_W-1:0] temperature_slope;
  logic signed [SAMPLE_W-1:0] pressure_slope;
  logic signed [SAMPLE_W-1:0] mach_slope;
  logic signed [SAMPLE_W-1:0] combined_slope;

  modport source (output valid, trend_state, confidence_pct, window_full, velocity_slope,
                  altitude_slope, temperature_slope, pressure_slope, mach_slope,
                  combined_slope, input ready);
  modport sink (input valid, trend_state, confidence_pct, window_full, velocity_slope,
                altitude_slope, temperature_slope, pressure_slope, mach_slope,
                combined_slope, output ready);
endinterface

interface mtc_cfg_if;
  import mtc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/mtc_lane.sv */
// ----------------------------------------------------------------------------
// mtc_lane
// One channel: sample window, least-squares slope, variance test, anomaly test.
// ----------------------------------------------------------------------------
module mtc_lane (
  input  logic                                clk_i,
  input  logic                                shift_i,
  input  logic signed [mtc_pkg::SAMPLE_W-1:0] sample_i,
  input  mtc_pkg::lane_ctrl_t                 ctrl_i,
  input  logic [mtc_pkg::LIMIT_W-1:0]         anom_limit_i,
  input  logic [mtc_pkg::VAR_W-1:0]           osc_thr_i,
  output mtc_pkg::lane_res_t                  res_o
);
  import mtc_pkg::*;

  logic signed [SAMPLE_W-1:0] taps_q [WINDOW_LEN];

  logic signed [PROD_W-1:0]   prod_q;
  logic [SQ_W-1:0]            sqr_q;
  logic signed [NUM_W-1:0]    num_q;
  logic signed [SY_W-1:0]     sy_q;
  logic [VAR_W-1:0]           ss_q;
  logic                       anom_q;
  logic                       neg_q;
  logic [NUM_W-1:0]           dvd_q;
  logic [NUM_W-1:0]           quo_q;
  logic [REM_W-1:0]           rem_q;
  logic [2*HALF_W-1:0]        symag_q;
  logic [2*HALF_W-1:0]        psq_q;
  logic [VAR_W-1:0]           sqacc_q;
  logic                       osc_q;

  logic                       walk_rd, walk_acc, div_setup, div_run;
  logic [IDX_W-1:0]           idx;
  logic [STEP_W-1:0]          dstep;
  logic signed [SAMPLE_W-1:0] y;
  logic [SAMPLE_W-1:0]        ymag;
  logic [HALF_W-1:0]          sy_hi, sy_lo;
  logic [VAR_W-1:0]           var_num;
  div_res_t                   dres;

  // Decode the shared step counter
  always_comb begin
    walk_rd   = ctrl_i.run && (ctrl_i.step < STEP_W'(WINDOW_LEN));
    walk_acc  = ctrl_i.run && (ctrl_i.step != '0) && (ctrl_i.step <= STEP_W'(WINDOW_LEN));
    div_setup = ctrl_i.run && (ctrl_i.step == STEP_W'(WINDOW_LEN + 1));
    div_run   = ctrl_i.run && (ctrl_i.step >= STEP_W'(WINDOW_LEN + 2)) &&
                (ctrl_i.step <= STEP_W'(WINDOW_LEN + 1 + DIV_CYC));
    dstep     = ctrl_i.step - STEP_W'(WINDOW_LEN + 2);
    idx       = ctrl_i.step[IDX_W-1:0];
    y         = taps_q[idx];
    ymag      = y[SAMPLE_W-1] ? SAMPLE_W'(-y) : SAMPLE_W'(y);
    sy_hi     = symag_q[2*HALF_W-1:HALF_W];
    sy_lo     = symag_q[HALF_W-1:0];
    var_num   = VAR_W'(ss_q) * VAR_W'(WINDOW_LEN) - sqacc_q;
    dres      = div_chunk(rem_q, dvd_q[NUM_W-1 -: CHUNK_W], REM_W'(SLOPE_DEN));
  end

  // Shift the new sample in at the young end
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int k = 0; k < WINDOW_LEN - 1; k++) begin
        taps_q[k] <= taps_q[k+1];
      end
      taps_q[WINDOW_LEN-1] <= sample_i;
    end
  end

  // Walk the window: one tap per cycle, products registered before the sum
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      num_q  <= '0;
      sy_q   <= '0;
      ss_q   <= '0;
      anom_q <= 1'b0;
    end else begin
      if (walk_rd) begin
        prod_q <= PROD_W'(tap_coef(idx)) * PROD_W'(y);
        sqr_q  <= SQ_W'(ymag) * SQ_W'(ymag);
        sy_q   <= sy_q + SY_W'(y);
        if (ymag > {1'b0, anom_limit_i}) anom_q <= 1'b1;
      end
      if (walk_acc) begin
        num_q <= num_q + NUM_W'(prod_q);
        ss_q  <= ss_q + VAR_W'(sqr_q);
      end
    end
  end

  // Divide the slope numerator, square the window sum and set the oscillation flag
  always_ff @(posedge clk_i) begin
    if (div_setup) begin
      neg_q   <= num_q[NUM_W-1];
      dvd_q   <= (num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q)) + NUM_W'(SLOPE_DEN / 2);
      quo_q   <= '0;
      rem_q   <= '0;
      symag_q <= (2*HALF_W)'(sy_q[SY_W-1] ? -sy_q : sy_q);
      sqacc_q <= '0;
    end else if (div_run) begin
      dvd_q <= dvd_q << CHUNK_W;
      quo_q <= {quo_q[NUM_W-CHUNK_W-1:0], dres.quo};
      rem_q <= dres.rem;
      case (dstep)
        STEP_W'(0): begin
          psq_q <= (2*HALF_W)'(sy_hi) * (2*HALF_W)'(sy_hi);
        end
        STEP_W'(1): begin
          sqacc_q <= sqacc_q + (VAR_W'(psq_q) << (2 * HALF_W));
          psq_q   <= (2*HALF_W)'(sy_hi) * (2*HALF_W)'(sy_lo);
        end
        STEP_W'(2): begin
          sqacc_q <= sqacc_q + (VAR_W'(psq_q) << (HALF_W + 1));
          psq_q   <= (2*HALF_W)'(sy_lo) * (2*HALF_W)'(sy_lo);
        end
        STEP_W'(3): begin
          sqacc_q <= sqacc_q + VAR_W'(psq_q);
        end
        STEP_W'(DIV_CYC - 1): begin
          osc_q <= (var_num >= osc_thr_i);
        end
        default: ;
      endcase
    end
  end

  // Round half away from zero already folded into the dividend
  always_comb begin
    res_o.slope = sat_sample(neg_q ? -$signed(quo_q) : $signed(quo_q));
    res_o.osc   = osc_q;
    res_o.anom  = anom_q;
  end

endmodule

/* rtl/mtc_merge.sv */
// ----------------------------------------------------------------------------
// mtc_merge
// Weighted trend over the lane slopes and classification of the window.
// ----------------------------------------------------------------------------
module mtc_merge (
  input  logic                                clk_i,
  input  mtc_pkg::mrg_ctrl_t                  ctrl_i,
  input  mtc_pkg::lane_res_t                  res_i [mtc_pkg::NUM_CH],
  input  mtc_pkg::trend_e                     held_i,
  input  logic [mtc_pkg::LIMIT_W-1:0]         stable_limit_i,
  input  logic signed [mtc_pkg::SAMPLE_W-1:0] rise_limit_i,
  input  logic signed [mtc_pkg::SAMPLE_W-1:0] fall_limit_i,
  output logic signed [mtc_pkg::SAMPLE_W-1:0] wt_o,
  output mtc_pkg::trend_e                     cls_o,
  output logic [mtc_pkg::CONF_W-1:0]          conf_o
);
  import mtc_pkg::*;

  logic                    neg_q;
  logic [NUM_W-1:0]        dvd_q;
  logic [NUM_W-1:0]        quo_q;
  logic [REM_W-1:0]        rem_q;

  logic signed [NUM_W-1:0] wsum;
  logic                    any_anom, any_osc;
  logic [SAMPLE_W-1:0]     wt_mag;
  div_res_t                dres;

  // Combine lane results
  always_comb begin
    wsum     = '0;
    any_anom = 1'b0;
    any_osc  = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      wsum     = wsum + NUM_W'(res_i[ch].slope) * NUM_W'(WEIGHT[ch]);
      any_anom = any_anom | res_i[ch].anom;
      any_osc  = any_osc | res_i[ch].osc;
    end
    dres = div_chunk(rem_q, dvd_q[NUM_W-1 -: CHUNK_W], REM_W'(WT_DEN));
  end

  // Divide the weighted sum by ten, eight bits per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      neg_q <= wsum[NUM_W-1];
      dvd_q <= (wsum[NUM_W-1] ? NUM_W'(-wsum) : NUM_W'(wsum)) + NUM_W'(WT_DEN / 2);
      quo_q <= '0;
      rem_q <= '0;
    end else if (ctrl_i.step) begin
      dvd_q <= dvd_q << CHUNK_W;
      quo_q <= {quo_q[NUM_W-CHUNK_W-1:0], dres.quo};
      rem_q <= dres.rem;
    end
  end

  // Classify by priority: anomaly, oscillation, rise, fall, stable, keep
  always_comb begin
    wt_o   = sat_sample(neg_q ? -$signed(quo_q) : $signed(quo_q));
    wt_mag = wt_o[SAMPLE_W-1] ? SAMPLE_W'(-wt_o) : SAMPLE_W'(wt_o);
    if (any_anom) begin
      cls_o  = TR_ANOM;
      conf_o = CONF_ANOM;
    end else if (any_osc) begin
      cls_o  = TR_OSC;
      conf_o = CONF_OSC;
    end else if (wt_o > rise_limit_i) begin
      cls_o  = TR_INC;
      conf_o = CONF_SLOPE;
    end else if (wt_o < fall_limit_i) begin
      cls_o  = TR_DEC;
      conf_o = CONF_SLOPE;
    end else if (wt_mag <= {1'b0, stable_limit_i}) begin
      cls_o  = TR_STABLE;
      conf_o = CONF_STABLE;
    end else begin
      cls_o  = held_i;
      conf_o = CONF_KEEP;
    end
  end

endmodule

/* rtl/multichannel_trend_classifier.sv */
// ----------------------------------------------------------------------------
// multichannel_trend_classifier
// Five-channel sliding-window trend classifier with hysteresis.
// ----------------------------------------------------------------------------
// For each sample item, five channel lanes walk their windows one tap per
// cycle in parallel, then each runs an eight-bit-per-cycle slope divider,
// after which the merge stage runs its own divider for the weighted trend.
// One item is in work at a time; a new item is taken while the previous
// result still waits in the output register. Results before the window
// fills report stable with zero confidence and zero trends.
`include "assert_macros.svh"

module multichannel_trend_classifier (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtc_in_if.sink    in_i,
  mtc_out_if.source out_o,
  mtc_cfg_if.sink   cfg_i
);
  import mtc_pkg::*;

  seq_e                       state_q, state_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic [CNT_W-1:0]           fill_q;
  trend_e                     held_q, held_d;
  logic [1:0]                 agree_q, agree_d;

  logic [LIMIT_W-1:0]         stable_lim_q, osc_lim_q, anom_lim_q;
  logic signed [SAMPLE_W-1:0] rise_lim_q, fall_lim_q;
  logic [VAR_W-1:0]           osc_thr_q;

  logic                       out_valid_q;
  trend_e                     trend_q;
  logic [CONF_W-1:0]          conf_q;
  logic                       full_q;
  logic signed [SAMPLE_W-1:0] slope_q [NUM_CH];
  logic signed [SAMPLE_W-1:0] wt_q;

  logic                       in_acc, out_load, win_full;
  lane_ctrl_t                 lane_ctrl;
  mrg_ctrl_t                  mrg_ctrl;
  logic signed [SAMPLE_W-1:0] samples [NUM_CH];
  lane_res_t                  lane_res [NUM_CH];
  logic signed [SAMPLE_W-1:0] wt;
  trend_e                     cls;
  logic [CONF_W-1:0]          conf;

  assign samples[0] = in_i.velocity_sample;
  assign samples[1] = in_i.altitude_sample;
  assign samples[2] = in_i.temperature_sample;
  assign samples[3] = in_i.pressure_sample;
  assign samples[4] = in_i.mach_sample;

  assign in_acc   = in_i.valid && in_i.ready;
  assign win_full = (fill_q == CNT_W'(WINDOW_LEN));

  // Sequencer: accept, lane walk and divide, merge divide, hand off
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    in_i.ready    = 1'b0;
    lane_ctrl     = '0;
    mrg_ctrl      = '0;
    out_load      = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = S_LANE;
          step_d  = '0;
        end
      end
      S_LANE: begin
        lane_ctrl.run  = 1'b1;
        lane_ctrl.step = step_q;
        if (step_q == STEP_W'(LANE_STEPS)) begin
          mrg_ctrl.load = 1'b1;
          state_d       = S_MERGE;
          step_d        = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_MERGE: begin
        mrg_ctrl.step = 1'b1;
        if (step_q == STEP_W'(DIV_CYC - 1)) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Count fills, saturating at the window length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (in_acc && !win_full) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  // Hysteresis: two agreeing classes in a row, anomaly passes at once
  always_comb begin
    agree_d = agree_q;
    held_d  = held_q;
    if (cls == held_q) begin
      if (agree_q != 2'd3) agree_d = agree_q + 1'b1;
    end else begin
      agree_d = 2'd1;
    end
    if (agree_d >= 2'd2 || cls == TR_ANOM) held_d = cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= TR_STABLE;
      agree_q <= '0;
    end else if (out_load && win_full) begin
      held_q  <= held_d;
      agree_q <= agree_d;
    end
  end

  // Register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_lim_q <= LIMIT_W'(32768);
      rise_lim_q   <= SAMPLE_W'(131072);
      fall_lim_q   <= -SAMPLE_W'(131072);
      osc_lim_q    <= LIMIT_W'(6553600);
      anom_lim_q   <= LIMIT_W'(65536000);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_STABLE: stable_lim_q <= cfg_i.data[LIMIT_W-1:0];
        REG_RISE:   rise_lim_q   <= cfg_i.data;
        REG_FALL:   fall_lim_q   <= cfg_i.data;
        REG_OSC:    osc_lim_q    <= cfg_i.data[LIMIT_W-1:0];
        REG_ANOM:   anom_lim_q   <= cfg_i.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Scale the oscillation limit to the unnormalized variance
  always_ff @(posedge clk_i) begin
    osc_thr_q <= (VAR_W'(osc_lim_q) + 1'b1) * VAR_W'(VAR_SCALE);
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    mtc_lane u_lane (
      .clk_i       (clk_i),
      .shift_i     (in_acc),
      .sample_i    (samples[ch]),
      .ctrl_i      (lane_ctrl),
      .anom_limit_i(anom_lim_q),
      .osc_thr_i   (osc_thr_q),
      .res_o       (lane_res[ch])
    );
  end

  mtc_merge u_merge (
    .clk_i         (clk_i),
    .ctrl_i        (mrg_ctrl),
    .res_i         (lane_res),
    .held_i        (held_q),
    .stable_limit_i(stable_lim_q),
    .rise_limit_i  (rise_lim_q),
    .fall_limit_i  (fall_lim_q),
    .wt_o          (wt),
    .cls_o         (cls),
    .conf_o        (conf)
  );

  // Output register; zeros until the window has filled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      full_q  <= win_full;
      trend_q <= win_full ? held_d : TR_STABLE;
      conf_q  <= win_full ? conf : '0;
      wt_q    <= win_full ? wt : '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        slope_q[ch] <= win_full ? lane_res[ch].slope : '0;
      end
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.trend_state       = trend_q;
  assign out_o.confidence_pct    = conf_q;
  assign out_o.window_full       = full_q;
  assign out_o.velocity_slope    = slope_q[0];
  assign out_o.altitude_slope    = slope_q[1];
  assign out_o.temperature_slope = slope_q[2];
  assign out_o.pressure_slope    = slope_q[3];
  assign out_o.mach_slope        = slope_q[4];
  assign out_o.combined_slope    = wt_q;

  `MTC_ASSERT(a_accept_starts_lanes, in_acc |=> (state_q == S_LANE), "accepted item did not start lanes")
  `MTC_ASSERT_IMPL(a_agree_needs_full, agree_q != 2'd0, fill_q == CNT_W'(WINDOW_LEN), "hysteresis moved before window filled")
  `MTC_ASSERT_IMPL(a_unfilled_zero, out_valid_q && !full_q, trend_q == TR_STABLE && conf_q == '0 && wt_q == '0, "unfilled result not zero")

endmodule

/* bench/multichannel_trend_classifier_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_trend_classifier_test
// Drives sample items through the five-channel trend classifier under random
// handshake gaps and several limit settings. An in-bench window model predicts
// each result item; a monitor compares every accepted result against it.
// ----------------------------------------------------------------------------
module multichannel_trend_classifier_test;
  import mtc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int Q1             = 65536;

  typedef struct {
    logic signed [31:0] smp [NUM_CH];
  } sample_item_t;

  typedef struct packed {
    logic [2:0]         state;
    logic [6:0]         conf;
    logic               full;
    logic signed [31:0] vel;
    logic signed [31:0] alt;
    logic signed [31:0] tmp;
    logic signed [31:0] prs;
    logic signed [31:0] mch;
    logic signed [31:0] wt;
  } trend_result_t;

  logic clk_i;
  logic rst_ni;

  mtc_in_if  in_bus ();
  mtc_out_if out_bus ();
  mtc_cfg_if cfg_bus ();

  multichannel_trend_classifier uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // Window model state and limits
  longint      win [NUM_CH][WINDOW_LEN];
  int          fill;
  logic [2:0]  held;
  logic [1:0]  agree;
  longint      lim_stable, lim_rise, lim_fall, lim_osc, lim_anom;

  trend_result_t expected_results [$];
  int          mismatches;
  int          idle_cycles;
  int          hold_left;
  int          stall_left;
  bit          rx_gaps;
  bit          tx_gaps;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Shift one item into the windows and classify it
  function automatic trend_result_t classify_item(sample_item_t it);
    trend_result_t r;
    longint        slope [NUM_CH];
    longint        sy, sxy, wt, d, m, awt;
    logic [127:0]  acc, thr;
    bit            anom, osc;
    logic [2:0]    cls;
    logic [6:0]    conf;
    for (int c = 0; c < NUM_CH; c++) begin
      for (int k = 0; k < WINDOW_LEN - 1; k++) win[c][k] = win[c][k+1];
      win[c][WINDOW_LEN-1] = longint'(it.smp[c]);
      slope[c] = 0;
    end
    if (fill < WINDOW_LEN) fill++;
    r = '0;
    if (fill < WINDOW_LEN) return r;
    anom = 0;
    osc = 0;
    for (int c = 0; c < NUM_CH; c++) begin
      sy = 0;
      sxy = 0;
      acc = '0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
        sy += win[c][k];
        sxy += longint'(k + 1) * win[c][k];
        m = (win[c][k] < 0) ? -win[c][k] : win[c][k];
        if (m > lim_anom) anom = 1;
        for (int j = k + 1; j < WINDOW_LEN; j++) begin
          d = win[c][k] - win[c][j];
          m = (d < 0) ? -d : d;
          acc += 128'(m) * 128'(m);
        end
      end
      slope[c] = clamp32(round_div(WINDOW_LEN * sxy - SUM_X * sy, SLOPE_DEN));
      thr = 128'(lim_osc + 1) * 128'(WINDOW_LEN * (WINDOW_LEN - 1)) * 128'(Q1);
      if (acc >= thr) osc = 1;
    end
    wt = clamp32(round_div(4 * slope[0] + 3 * slope[1] + slope[2] + slope[3] + slope[4],
                           10));
    awt = (wt < 0) ? -wt : wt;
    if (anom) begin
      cls = TR_ANOM; conf = CONF_ANOM;
    end else if (osc) begin
      cls = TR_OSC; conf = CONF_OSC;
    end else if (wt > lim_rise) begin
      cls = TR_INC; conf = CONF_SLOPE;
    end else if (wt < lim_fall) begin
      cls = TR_DEC; conf = CONF_SLOPE;
    end else if (awt <= lim_stable) begin
      cls = TR_STABLE; conf = CONF_STABLE;
    end else begin
      cls = held; conf = CONF_KEEP;
    end
    // Two-in-a-row hysteresis, bypassed by anomaly
    if (cls == held) begin
      if (agree < 2'd3) agree++;
    end else begin
      agree = 2'd1;
    end
    if (agree >= 2'd2 || cls == TR_ANOM) held = cls;
    r.state = held;
    r.conf  = conf;
    r.full  = 1'b1;
    r.vel   = 32'(slope[0]);
    r.alt   = 32'(slope[1]);
    r.tmp   = 32'(slope[2]);
    r.prs   = 32'(slope[3]);
    r.mch   = 32'(slope[4]);
    r.wt    = 32'(wt);
    return r;
  endfunction

  // Offer one item and hold it until accepted, then maybe idle
  task automatic send_item(sample_item_t it);
    int gap;
    in_bus.valid              <= 1'b1;
    in_bus.velocity_sample    <= it.smp[0];
    in_bus.altitude_sample    <= it.smp[1];
    in_bus.temperature_sample <= it.smp[2];
    in_bus.pressure_sample    <= it.smp[3];
    in_bus.mach_sample        <= it.smp[4];
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    expected_results.push_back(classify_item(it));
    gap = 0;
    if (tx_gaps && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one limit register; only called while the block is idle
  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    case (idx)
      REG_STABLE: lim_stable = longint'(val[30:0]);
      REG_RISE:   lim_rise   = longint'(signed'(val));
      REG_FALL:   lim_fall   = longint'(signed'(val));
      REG_OSC:    lim_osc    = longint'(val[30:0]);
      REG_ANOM:   lim_anom   = longint'(val[30:0]);
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic sample_item_t fill_item(longint v0, longint v1, longint v2,
                                             longint v3, longint v4);
    sample_item_t it;
    it.smp[0] = 32'(v0);
    it.smp[1] = 32'(v1);
    it.smp[2] = 32'(v2);
    it.smp[3] = 32'(v3);
    it.smp[4] = 32'(v4);
    return it;
  endfunction

  function automatic longint rand_signed(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Directed: fill, ramps, keep-last, anomaly, extremes, alternation
  task automatic test_directed();
    for (int k = 0; k < 10; k++) send_item(fill_item(0, 0, 0, 0, 0));
    for (int k = 1; k <= 4; k++)
      send_item(fill_item(k * 3 * Q1, k * 3 * Q1, 0, 0, 0));
    for (int k = 1; k <= 3; k++)
      send_item(fill_item(-k * 9 * Q1, -k * 9 * Q1, 0, 0, 0));
    send_item(fill_item(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                        64'sd2147483647, 64'sd2147483647));
    send_item(fill_item(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                        -64'sd2147483648, -64'sd2147483648));
    send_item(fill_item(64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
                        -64'sd2147483648, 64'sd2147483647));
    send_item(fill_item(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                        64'sd2147483647, -64'sd2147483648));
    drain_results();
  endtask

  // Random segments: ramps, flat, noise, full range, spikes
  task automatic run_random(int count);
    longint base [NUM_CH];
    longint stp [NUM_CH];
    int     mode, seg, sent;
    sample_item_t it;
    sent = 0;
    while (sent < count) begin
      mode = $urandom_range(0, 9);
      seg = $urandom_range(4, 24);
      for (int c = 0; c < NUM_CH; c++) begin
        base[c] = rand_signed(600 * Q1);
        stp[c] = (mode < 5) ? rand_signed(5 * Q1) : 0;
      end
      for (int k = 0; k < seg && sent < count; k++) begin
        for (int c = 0; c < NUM_CH; c++) begin
          case (mode)
            0, 1, 2, 3, 4: it.smp[c] = 32'(base[c] + k * stp[c] + rand_signed(Q1 / 4));
            5, 6:          it.smp[c] = 32'(base[c] + rand_signed(Q1 / 2));
            7:             it.smp[c] = 32'(base[c] + rand_signed(40 * Q1));
            8:             it.smp[c] = 32'($urandom());
            default:       it.smp[c] = ($urandom_range(0, 4) == 0) ?
                                       32'(rand_signed(2000 * Q1)) : 32'(base[c]);
          endcase
        end
        send_item(it);
        sent++;
      end
    end
    drain_results();
  endtask

  task automatic test_default_limits();
    run_random(300);
  endtask

  task automatic test_low_extremes();
    write_limit(REG_STABLE, 32'h0);
    write_limit(REG_RISE, 32'h8000_0000);
    write_limit(REG_FALL, 32'h8000_0000);
    write_limit(REG_OSC, 32'h0);
    write_limit(REG_ANOM, 32'h0);
    run_random(120);
  endtask

  task automatic test_high_extremes();
    write_limit(REG_STABLE, 32'hFFFF_FFFF);
    write_limit(REG_RISE, 32'h7FFF_FFFF);
    write_limit(REG_FALL, 32'h7FFF_FFFF);
    write_limit(REG_OSC, 32'hFFFF_FFFF);
    write_limit(REG_ANOM, 32'hFFFF_FFFF);
    run_random(120);
  endtask

  task automatic test_random_limits();
    for (int p = 0; p < 3; p++) begin
      write_limit(REG_STABLE, {1'b1, 31'($urandom_range(0, 3 * Q1))});
      write_limit(REG_RISE, 32'(rand_signed(4 * Q1)));
      write_limit(REG_FALL, 32'(rand_signed(4 * Q1)));
      write_limit(REG_OSC, 32'($urandom_range(0, 400 * Q1)));
      write_limit(REG_ANOM, 32'($urandom_range(200 * Q1, 1500 * Q1)));
      write_limit(CFG_IDX_W'(5 + $urandom_range(0, 2)), $urandom());
      run_random(180);
    end
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    write_limit(REG_STABLE, 32'(Q1 / 2));
    write_limit(REG_RISE, 32'(2 * Q1));
    write_limit(REG_FALL, -32'sd131072);
    write_limit(REG_OSC, 32'(100 * Q1));
    write_limit(REG_ANOM, 32'(1000 * Q1));
    hold_left <= 400;
    run_random(40);
    rx_gaps = 0;
    tx_gaps = 0;
    run_random(150);
    rx_gaps = 1;
    tx_gaps = 1;
    run_random(200);
  endtask

  // Result ready with random stalls and an occasional long hold
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_bus.ready <= 1'b1;
      if (rx_gaps && $urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    trend_result_t got, want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = {out_bus.trend_state, out_bus.confidence_pct, out_bus.window_full,
             out_bus.velocity_slope, out_bus.altitude_slope, out_bus.temperature_slope,
             out_bus.pressure_slope, out_bus.mach_slope, out_bus.combined_slope};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got.state !== want.state || got.conf !== want.conf || got.full !== want.full ||
            got.vel !== want.vel || got.alt !== want.alt || got.tmp !== want.tmp ||
            got.prs !== want.prs || got.mch !== want.mch || got.wt !== want.wt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t\n  expected %p\n  actual   %p", $realtime, want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("multichannel_trend_classifier_test: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.velocity_sample = '0;
    in_bus.altitude_sample = '0;
    in_bus.temperature_sample = '0;
    in_bus.pressure_sample = '0;
    in_bus.mach_sample = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    mismatches = 0;
    idle_cycles = 0;
    hold_left = 0;
    stall_left = 0;
    rx_gaps = 1;
    tx_gaps = 1;
    for (int c = 0; c < NUM_CH; c++)
      for (int k = 0; k < WINDOW_LEN; k++) win[c][k] = 0;
    fill = 0;
    held = TR_STABLE;
    agree = 2'd0;
    lim_stable = 32768;
    lim_rise = 131072;
    lim_fall = -131072;
    lim_osc = 6553600;
    lim_anom = 65536000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_default_limits();
    test_low_extremes();
    test_high_extremes();
    test_random_limits();
    test_backpressure();

    drain_results();
    mismatches += expected_results.size();
    if (mismatches == 0)
      $display("multichannel_trend_classifier_test: PASS");
    else
      $display("multichannel_trend_classifier_test: FAIL");
    $finish;
  end

endmodule
